@@ sv/lfpg_pkg.sv @@
`timescale 1ns / 1ps

package lfpg_pkg;

    // Field widths.
    localparam int unsigned CNT_W      = 8;
    localparam int unsigned REQ_W      = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    // Completed PWM periods per flash count step.
    localparam logic [CNT_W-1:0] PRESCALE = 8'd10;

    // Request codes carried by req_type.
    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 2'd0,
        REQ_START = 2'd1,
        REQ_STOP  = 2'd2,
        REQ_PHASE = 2'd3
    } req_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_DUTY      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_PERIOD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_DUTY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_TOTAL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 3'd5;

    // Pattern settings as seen by the counter core.
    typedef struct packed {
        logic [CNT_W-1:0] pwm_period;
        logic [CNT_W-1:0] pwm_duty;
        logic [CNT_W-1:0] flash_period;
        logic [CNT_W-1:0] flash_duty;
        logic [CNT_W-1:0] flash_total;
        logic [CNT_W-1:0] repeat_period;
    } cfg_t;

    // Result of one processed transaction.
    typedef struct packed {
        logic has_result;
        logic drive;
        logic running;
    } result_t;

endpackage

@@ sv/lfpg_cfg_regs.sv @@
`timescale 1ns / 1ps

module lfpg_cfg_regs
    import lfpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index; unused indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PWM_PERIOD:    cfg_next.pwm_period    = cfg_wdata;
                CFG_PWM_DUTY:      cfg_next.pwm_duty      = cfg_wdata;
                CFG_FLASH_PERIOD:  cfg_next.flash_period  = cfg_wdata;
                CFG_FLASH_DUTY:    cfg_next.flash_duty    = cfg_wdata;
                CFG_FLASH_TOTAL:   cfg_next.flash_total   = cfg_wdata;
                CFG_REPEAT_PERIOD: cfg_next.repeat_period = cfg_wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/lfpg_core.sv @@
`timescale 1ns / 1ps

module lfpg_core
    import lfpg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             step,
    input  req_t             req,
    input  logic [CNT_W-1:0] phase,
    output result_t          result
);

    logic [CNT_W-1:0] pwm_count_reg,      pwm_count_next;
    logic [CNT_W-1:0] prescale_count_reg, prescale_count_next;
    logic [CNT_W-1:0] flash_count_reg,    flash_count_next;
    logic [CNT_W-1:0] sequence_count_reg, sequence_count_next;
    logic             active_reg,         active_next;

    logic [CNT_W-1:0] pwm_inc;
    logic [CNT_W-1:0] prescale_inc;
    logic [CNT_W-1:0] flash_inc;
    logic [CNT_W-1:0] sequence_inc;
    logic             pwm_wrap;
    logic             prescale_wrap;
    logic             flash_wrap;
    logic             sequence_wrap;
    logic             one_shot_end;
    logic             lit;

    // Nested counter increments, each wrapping at 8 bits before the compare.
    always_comb
    begin
        pwm_inc       = pwm_count_reg + CNT_W'(1);
        prescale_inc  = prescale_count_reg + CNT_W'(1);
        flash_inc     = flash_count_reg + CNT_W'(1);
        sequence_inc  = sequence_count_reg + CNT_W'(1);
        pwm_wrap      = (pwm_inc >= cfg.pwm_period);
        prescale_wrap = pwm_wrap && (prescale_inc >= PRESCALE);
        flash_wrap    = prescale_wrap && (flash_inc >= cfg.flash_period);
        one_shot_end  = flash_wrap && (cfg.repeat_period == '0)
                        && (sequence_inc >= cfg.flash_total);
        sequence_wrap = flash_wrap && (cfg.repeat_period != '0)
                        && (sequence_inc >= cfg.repeat_period);
    end

    // Next state and result for the transaction in hand.
    always_comb
    begin
        pwm_count_next      = pwm_count_reg;
        prescale_count_next = prescale_count_reg;
        flash_count_next    = flash_count_reg;
        sequence_count_next = sequence_count_reg;
        active_next         = active_reg;
        result              = '0;
        lit                 = 1'b0;

        if (step)
        begin
            unique case (req)
                REQ_START:
                begin
                    pwm_count_next      = '0;
                    prescale_count_next = '0;
                    flash_count_next    = '0;
                    sequence_count_next = '0;
                    active_next         = 1'b1;
                end
                REQ_STOP:
                begin
                    pwm_count_next      = '0;
                    prescale_count_next = '0;
                    flash_count_next    = '0;
                    sequence_count_next = '0;
                    active_next         = 1'b0;
                end
                REQ_PHASE:
                begin
                    pwm_count_next      = '0;
                    flash_count_next    = '0;
                    sequence_count_next = phase;
                end
                default:
                begin
                    // A tick always gives a result; idle ticks leave state alone.
                    result.has_result = 1'b1;
                    if (active_reg)
                    begin
                        pwm_count_next = pwm_wrap ? '0 : pwm_inc;
                        if (pwm_wrap)
                        begin
                            prescale_count_next = prescale_wrap ? '0 : prescale_inc;
                        end
                        if (prescale_wrap)
                        begin
                            flash_count_next = flash_wrap ? '0 : flash_inc;
                        end
                        if (flash_wrap)
                        begin
                            sequence_count_next = sequence_wrap ? '0 : sequence_inc;
                        end

                        lit = (pwm_count_next < cfg.pwm_duty)
                              && (flash_count_next < cfg.flash_duty)
                              && (sequence_count_next < cfg.flash_total);

                        if (one_shot_end)
                        begin
                            // Last flash of a one-shot: final high, then stop.
                            active_next    = 1'b0;
                            result.drive   = 1'b1;
                            result.running = 1'b0;
                        end
                        else
                        begin
                            result.drive   = lit;
                            result.running = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_count_reg      <= '0;
            prescale_count_reg <= '0;
            flash_count_reg    <= '0;
            sequence_count_reg <= '0;
            active_reg         <= 1'b0;
        end
        else
        begin
            pwm_count_reg      <= pwm_count_next;
            prescale_count_reg <= prescale_count_next;
            flash_count_reg    <= flash_count_next;
            sequence_count_reg <= sequence_count_next;
            active_reg         <= active_next;
        end
    end

endmodule

@@ sv/led_flash_pattern_generator.sv @@
`timescale 1ns / 1ps
// A tick transaction is held in the input register until the core can step it; its result
// is then written to the result register, from which out_valid, drive and running are read.
// Throughput: one transaction per cycle while the result register drains; the counter
// update and compares of the core are combinational, so the core can step every cycle.
// A tick waits in the input register while the result register is full and not being read.
// Reset: counters, pattern active flag and all settings clear to zero; no result pending.

module led_flash_pattern_generator
    import lfpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [REQ_W-1:0]      req_type,
    input  logic [CNT_W-1:0]      phase,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  drive,
    output logic                  running
);

    cfg_t             cfg;
    result_t          result;

    logic             in_valid_reg;
    logic             in_valid_next;
    req_t             req_reg;
    logic [CNT_W-1:0] phase_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             drive_reg;
    logic             running_reg;

    logic             in_fire;
    logic             out_room;
    logic             step;

    lfpg_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The staged transaction moves on when it has no result or the result register is free.
    assign out_room = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && ((req_reg != REQ_TICK) || out_room);
    assign in_ready = !in_valid_reg || step;
    assign in_fire  = in_valid && in_ready;

    lfpg_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (step),
        .req    (req_reg),
        .phase  (phase_reg),
        .result (result)
    );

    // Handshake state for the input and result registers.
    always_comb
    begin
        in_valid_next  = in_fire ? 1'b1 : (step ? 1'b0 : in_valid_reg);
        out_valid_next = result.has_result ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers load without reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg   <= req_t'(req_type);
            phase_reg <= phase;
        end
        if (result.has_result)
        begin
            drive_reg   <= result.drive;
            running_reg <= result.running;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign running   = running_reg;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import lfpg_pkg::*;

    localparam int unsigned LIMIT           = 400000;
    localparam int unsigned PHASES          = 8;
    localparam int unsigned ITEMS_PER_PHASE = 80;
    localparam int unsigned SETTLE          = 4;
    localparam int unsigned TAIL            = 8;
    localparam int unsigned HOLD_PHASE      = 4;
    localparam int unsigned HOLD_CYCLES     = 200;
    localparam int unsigned DIRECTED_ROWS   = 23;

    // Register indexes past the last register; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // One row of the directed table. When fixed is set, drive and running
    // give the expected result directly.
    typedef struct packed {
        req_t             req;
        logic [CNT_W-1:0] ph;
        logic             fixed;
        logic             drive;
        logic             running;
    } step_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_ready;
    logic [REQ_W-1:0]      req_type;
    logic [CNT_W-1:0]      phase;
    logic                  out_valid;
    logic                  out_ready;
    logic                  drive;
    logic                  running;

    // Pattern state as the predictor tracks it.
    cfg_t             pred_cfg;
    logic [CNT_W-1:0] pred_pwm_cnt;
    logic [CNT_W-1:0] pred_prescale_cnt;
    logic [CNT_W-1:0] pred_flash_cnt;
    logic [CNT_W-1:0] pred_seq_cnt;
    logic             pred_active;

    result_t     pending_levels[$];
    step_row_t   directed_rows [DIRECTED_ROWS];
    int unsigned failures     = 0;
    int unsigned results_seen = 0;
    int unsigned items_sent   = 0;
    int unsigned src_mode     = 0;
    int unsigned cycle_count  = 0;
    logic        hold_ask     = 1'b0;

    led_flash_pattern_generator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .phase     (phase),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .drive     (drive),
        .running   (running)
    );

    always #2 clk = ~clk;

    // Advance the predicted pattern by one request and return its result.
    function automatic result_t pattern_step(input req_t req, input logic [CNT_W-1:0] ph);
        result_t res;
        logic    last_flash;
        res = '0;
        last_flash = 1'b0;
        case (req)
            REQ_START, REQ_STOP:
            begin
                pred_pwm_cnt      = '0;
                pred_prescale_cnt = '0;
                pred_flash_cnt    = '0;
                pred_seq_cnt      = '0;
                pred_active       = (req == REQ_START);
            end
            REQ_PHASE:
            begin
                pred_pwm_cnt   = '0;
                pred_flash_cnt = '0;
                pred_seq_cnt   = ph;
            end
            default:
            begin
                res.has_result = 1'b1;
                if (pred_active)
                begin
                    // Nested counters, each wrapping at 8 bits before the compare.
                    pred_pwm_cnt = pred_pwm_cnt + 8'd1;
                    if (pred_pwm_cnt >= pred_cfg.pwm_period)
                    begin
                        pred_pwm_cnt      = '0;
                        pred_prescale_cnt = pred_prescale_cnt + 8'd1;
                        if (pred_prescale_cnt >= PRESCALE)
                        begin
                            pred_prescale_cnt = '0;
                            pred_flash_cnt    = pred_flash_cnt + 8'd1;
                            if (pred_flash_cnt >= pred_cfg.flash_period)
                            begin
                                pred_flash_cnt = '0;
                                pred_seq_cnt   = pred_seq_cnt + 8'd1;
                                if (pred_cfg.repeat_period == '0)
                                begin
                                    last_flash = (pred_seq_cnt >= pred_cfg.flash_total);
                                end
                                else if (pred_seq_cnt >= pred_cfg.repeat_period)
                                begin
                                    pred_seq_cnt = '0;
                                end
                            end
                        end
                    end
                    // The one-shot pattern ends with a final lit tick.
                    if (last_flash)
                    begin
                        pred_active = 1'b0;
                        res.drive   = 1'b1;
                        res.running = 1'b0;
                    end
                    else
                    begin
                        res.drive   = (pred_pwm_cnt < pred_cfg.pwm_duty)
                                   && (pred_flash_cnt < pred_cfg.flash_duty)
                                   && (pred_seq_cnt < pred_cfg.flash_total);
                        res.running = 1'b1;
                    end
                end
            end
        endcase
        return res;
    endfunction

    function automatic logic [CNT_W-1:0] rand_byte();
        return CNT_W'($urandom_range(0, 255));
    endfunction

    // Idle cycles before the next transaction, shaped by the current sender mode.
    function automatic int unsigned sender_gap();
        int unsigned r;
        int unsigned gap;
        r = $urandom_range(0, 99);
        gap = 0;
        if (src_mode == 1 && r < 25)
        begin
            gap = $urandom_range(1, 3);
        end
        else if (src_mode == 2)
        begin
            if (r < 45)
            begin
                gap = $urandom_range(1, 3);
            end
            else if (r < 50)
            begin
                gap = $urandom_range(10, 40);
            end
        end
        return gap;
    endfunction

    // Offer one request, wait for its acceptance and record what it should produce.
    // Entered and left at a falling edge.
    task automatic push_request(input req_t r, input logic [CNT_W-1:0] ph,
                                input logic fixed, input logic fdrive,
                                input logic frunning);
        int unsigned gap;
        result_t     res;
        if (items_sent % 50 == 0)
        begin
            src_mode = $urandom_range(0, 2);
        end
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= r;
        phase    <= ph;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        items_sent++;
        res = pattern_step(r, ph);
        if (res.has_result)
        begin
            if (fixed)
            begin
                res.drive   = fdrive;
                res.running = frunning;
            end
            pending_levels.push_back(res);
        end
        @(negedge clk);
    endtask

    // Let every outstanding result drain, then give the core time to finish
    // any request that produces no result.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_levels.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        case (idx)
            CFG_PWM_PERIOD:    pred_cfg.pwm_period    = v;
            CFG_PWM_DUTY:      pred_cfg.pwm_duty      = v;
            CFG_FLASH_PERIOD:  pred_cfg.flash_period  = v;
            CFG_FLASH_DUTY:    pred_cfg.flash_duty    = v;
            CFG_FLASH_TOTAL:   pred_cfg.flash_total   = v;
            CFG_REPEAT_PERIOD: pred_cfg.repeat_period = v;
            default:           ;
        endcase
        @(negedge clk);
    endtask

    // Program the pattern for one phase: all ones, all zeros, then small random
    // periods, which keep flashes, sequence wraps and one-shot ends frequent.
    task automatic load_settings(input int unsigned p);
        cfg_t s;
        if (p == 0)
        begin
            s = '1;
        end
        else if (p == 1)
        begin
            s = '0;
        end
        else
        begin
            s.pwm_period    = CNT_W'($urandom_range(0, 3));
            s.pwm_duty      = CNT_W'($urandom_range(0, 4));
            s.flash_period  = CNT_W'($urandom_range(0, 3));
            s.flash_duty    = CNT_W'($urandom_range(0, 4));
            s.flash_total   = CNT_W'($urandom_range(0, 5));
            s.repeat_period = ($urandom_range(0, 1) != 0) ? CNT_W'($urandom_range(1, 6)) : '0;
            if (p == 2)
            begin
                s.pwm_duty   = '1;
                s.flash_duty = '1;
            end
        end
        write_reg(CFG_PWM_PERIOD,    s.pwm_period);
        write_reg(CFG_PWM_DUTY,      s.pwm_duty);
        write_reg(CFG_FLASH_PERIOD,  s.flash_period);
        write_reg(CFG_FLASH_DUTY,    s.flash_duty);
        write_reg(CFG_FLASH_TOTAL,   s.flash_total);
        write_reg(CFG_REPEAT_PERIOD, s.repeat_period);
        write_reg(p[0] ? CFG_SPARE_HI : CFG_SPARE_LO, rand_byte());
        cfg_we <= 1'b0;
    endtask

    // Request stimulus: directed table, then random phases under varied settings.
    initial
    begin
        int unsigned n;
        int unsigned burst;
        int unsigned pick;
        step_row_t   row;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        req_type  = REQ_TICK;
        phase     = '0;
        pred_cfg          = '0;
        pred_pwm_cnt      = '0;
        pred_prescale_cnt = '0;
        pred_flash_cnt    = '0;
        pred_seq_cnt      = '0;
        pred_active       = 1'b0;

        // All settings are zero here: every tick wraps the PWM counter, and the
        // tenth tick after a start ends the one-shot pattern.
        directed_rows = '{
            '{REQ_TICK,  8'h00, 1'b1, 1'b0, 1'b0},
            '{REQ_PHASE, 8'hFF, 1'b0, 1'b0, 1'b0},
            '{REQ_TICK,  8'hFF, 1'b1, 1'b0, 1'b0},
            '{REQ_STOP,  8'h00, 1'b0, 1'b0, 1'b0},
            '{REQ_TICK,  8'h55, 1'b1, 1'b0, 1'b0},
            '{REQ_START, 8'hAA, 1'b0, 1'b0, 1'b0},
            '{REQ_TICK,  8'h01, 1'b0, 1'b0, 1'b0},
            '{REQ_TICK,  8'h02, 1'b0, 1'b0, 1'b0},
            '{REQ_TICK,  8'h04, 1'b0, 1'b0, 1'b0},
            '{REQ_TICK,  8'h08, 1'b0, 1'b0, 1'b0},
            '{REQ_TICK,  8'h10, 1'b0, 1'b0, 1'b0},
            '{REQ_TICK,  8'h20, 1'b0, 1'b0, 1'b0},
            '{REQ_TICK,  8'h40, 1'b0, 1'b0, 1'b0},
            '{REQ_TICK,  8'h80, 1'b0, 1'b0, 1'b0},
            '{REQ_TICK,  8'h00, 1'b0, 1'b0, 1'b0},
            '{REQ_TICK,  8'hFF, 1'b1, 1'b1, 1'b0},
            '{REQ_TICK,  8'h00, 1'b1, 1'b0, 1'b0},
            '{REQ_START, 8'h00, 1'b0, 1'b0, 1'b0},
            '{REQ_PHASE, 8'h00, 1'b0, 1'b0, 1'b0},
            '{REQ_TICK,  8'h00, 1'b0, 1'b0, 1'b0},
            '{REQ_START, 8'hFF, 1'b0, 1'b0, 1'b0},
            '{REQ_STOP,  8'hFF, 1'b0, 1'b0, 1'b0},
            '{REQ_TICK,  8'h00, 1'b1, 1'b0, 1'b0}
        };

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = directed_rows[i];
            push_request(row.req, row.ph, row.fixed, row.drive, row.running);
        end

        for (int unsigned p = 0; p < PHASES; p++)
        begin
            wait_idle();
            load_settings(p);
            if (p == HOLD_PHASE)
            begin
                hold_ask = 1'b1;
            end
            n = 0;
            while (n < ITEMS_PER_PHASE)
            begin
                // Mostly a start followed by a run of ticks, with stray requests mixed in.
                burst = $urandom_range(4, 40);
                if ($urandom_range(0, 9) != 0)
                begin
                    push_request(REQ_START, rand_byte(), 1'b0, 1'b0, 1'b0);
                    n++;
                end
                repeat (burst)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 88)
                    begin
                        push_request(REQ_TICK, rand_byte(), 1'b0, 1'b0, 1'b0);
                    end
                    else if (pick < 94)
                    begin
                        push_request(REQ_PHASE, rand_byte(), 1'b0, 1'b0, 1'b0);
                    end
                    else if (pick < 97)
                    begin
                        push_request(REQ_STOP, rand_byte(), 1'b0, 1'b0, 1'b0);
                    end
                    else
                    begin
                        push_request(REQ_START, rand_byte(), 1'b0, 1'b0, 1'b0);
                    end
                    n++;
                end
            end
        end

        // Drain, then allow the pipeline latency before the verdict.
        in_valid <= 1'b0;
        while (pending_levels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL) @(posedge clk);
        if (failures == 0)
        begin
            $display("[led_flash_pattern_generator] OK");
        end
        else
        begin
            $display("[led_flash_pattern_generator] ERROR");
        end
        $finish;
    end

    // Result acceptance with random back-pressure and one long hold-off.
    initial
    begin
        int unsigned stall_left;
        int unsigned mode;
        int unsigned cyc;
        int unsigned r;
        logic        hold_done;
        stall_left = 0;
        mode       = 0;
        cyc        = 0;
        hold_done  = 1'b0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 128 == 0)
            begin
                mode = $urandom_range(0, 2);
            end
            if (hold_ask && !hold_done)
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                r = $urandom_range(0, 99);
                if (mode == 1 && r < 25)
                begin
                    stall_left = $urandom_range(1, 3);
                end
                else if (mode == 2 && r < 40)
                begin
                    stall_left = $urandom_range(1, 3);
                end
                else if (mode == 2 && r < 44)
                begin
                    stall_left = $urandom_range(15, 50);
                end
            end
        end
    end

    // Compare each accepted result transaction with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_levels.size() == 0)
            begin
                $error("unexpected result: drive %0b running %0b", drive, running);
                failures++;
            end
            else
            begin
                want = pending_levels.pop_front();
                if (drive !== want.drive)
                begin
                    $error("drive mismatch: expected %0b, got %0b", want.drive, drive);
                    failures++;
                end
                if (running !== want.running)
                begin
                    $error("running mismatch: expected %0b, got %0b", want.running, running);
                    failures++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[led_flash_pattern_generator] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
sv/lfpg_pkg.sv
sv/lfpg_cfg_regs.sv
sv/lfpg_core.sv
sv/led_flash_pattern_generator.sv
test/testbench.sv
